[rtl/consistent_hash_ring_macros.svh]
// Assertion helpers for the hash ring block.
`ifndef CONSISTENT_HASH_RING_MACROS_SVH
`define CONSISTENT_HASH_RING_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the same cycle.
`define CHR_IMPLIES(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

[rtl/chr_pkg.sv]
package chr_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_KEPT     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam int SEEN_W    = 64;
  localparam int REPLICA_W = 16;

  typedef struct packed {
    logic [31:0] hash;
    logic [5:0]  owner;
    logic [15:0] weight;
    logic [31:0] ip;
    logic [15:0] port;
  } entry_t;

endpackage

[rtl/chr_if.sv]
interface chr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] point_hash;
  logic [5:0]  instance_id;
  logic [15:0] weight;
  logic [31:0] ip_address;
  logic [15:0] port_number;
  logic [15:0] replica;
  modport source (output valid, op, point_hash, instance_id, weight, ip_address,
                  port_number, replica, input ready);
  modport sink (input valid, op, point_hash, instance_id, weight, ip_address,
                port_number, replica, output ready);
endinterface

interface chr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] chosen_instance;
  modport source (output valid, status, chosen_instance, input ready);
  modport sink (input valid, status, chosen_instance, output ready);
endinterface

[rtl/chr_cell.sv]
module chr_cell (
  input  logic            clk,
  input  logic            shift,
  input  chr_pkg::entry_t nbr,
  output chr_pkg::entry_t cur
);
  import chr_pkg::*;

  entry_t data;

  // Take the neighbor's entry on every shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nbr;
    end
  end

  assign cur = data;
endmodule

[rtl/chr_chain.sv]
module chr_chain #(
  parameter int RING_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            shift,
  input  chr_pkg::entry_t tail,
  output chr_pkg::entry_t head
);
  import chr_pkg::*;

  entry_t link [RING_DEPTH+1];

  assign link[RING_DEPTH] = tail;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    chr_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .nbr   (link[i+1]),
      .cur   (link[i])
    );
  end

  assign head = link[0];
endmodule

[rtl/consistent_hash_ring.sv]
// Channel   Dir  Payload
// in_ch     in   op, point_hash, instance_id, weight, ip_address, port_number, replica
// out_ch    out  status, chosen_instance
// cfg       in   cfg_we, cfg_data (instance_count)
//
// Each transaction is accepted in S_IDLE, scanned, and answered from S_RESP.
// Clear, empty-ring lookup: no scan.
// Insert: one full turn of the cell chain past the head.
// Lookup: replica remainder in S_DIV, then one turn of the chain, plus two
//   more turns when the reduced replica is nonzero (the walk).
// Reset (rst, synchronous) empties the ring; the cells themselves are not cleared.
// A result waiting on out_ch holds the next transaction in S_RESP until it is taken.
module consistent_hash_ring #(
  parameter int RING_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst,
  chr_in_if.sink          in_ch,
  chr_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data
);
  import chr_pkg::*;
  `include "consistent_hash_ring_macros.svh"

  localparam int STEP_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RING_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_ROT  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic [1:0]          pass;
  logic [CNT_W-1:0]    count;
  logic [6:0]          inst_cnt;

  // Latched transaction
  logic [1:0]          op_r;
  entry_t              nw;
  logic [REPLICA_W-1:0] rep_bits;

  // Replica remainder, one quotient bit a cycle
  logic [6:0]          rem;
  logic [4:0]          div_cnt;
  logic [7:0]          rem_sh;
  logic [6:0]          modulus;

  // Insert scan
  logic                decided;
  logic                ins;
  entry_t              hold;

  // Lookup scan and walk
  logic                found;
  logic [STEP_W-1:0]   prim_idx;
  logic [5:0]          prim;
  logic [5:0]          owner0;
  logic [SEEN_W-1:0]   seen;
  logic [6:0]          distinct;
  logic                done;
  logic [5:0]          ans;

  logic [2:0]          res_status;
  logic [5:0]          res_inst;

  // Chain
  entry_t              head;
  entry_t              tail;
  logic                shift;

  logic [CNT_W-1:0]    stepx;
  logic                in_ring;
  logic                at_pos;
  logic                coll;
  logic                take;
  logic                full;
  logic                hit;
  logic [5:0]          prim_f;
  logic [STEP_W-1:0]   prim_idx_f;
  logic [SEEN_W-1:0]   bit_sel;
  logic                new_bit;
  logic [6:0]          dist_n;
  logic                walk;

  chr_chain #(.RING_DEPTH(RING_DEPTH)) u_chain (
    .clk   (clk),
    .shift (shift),
    .tail  (tail),
    .head  (head)
  );

  assign shift   = (state == S_ROT);
  assign stepx   = CNT_W'(step);
  assign in_ring = stepx < count;
  assign full    = count == CNT_W'(RING_DEPTH);
  assign at_pos  = (stepx == count) || (in_ring && head.hash >= nw.hash);
  assign coll    = in_ring && head.hash == nw.hash;

  // New point wins on larger weight, then lower IP, then lower or equal port.
  always_comb begin
    if (nw.weight != head.weight) begin
      take = nw.weight > head.weight;
    end else if (nw.ip != head.ip) begin
      take = nw.ip < head.ip;
    end else begin
      take = nw.port <= head.port;
    end
  end

  // What re-enters the chain tail at this step.
  always_comb begin
    tail = head;
    if (op_r == OP_INSERT) begin
      if (ins) begin
        tail = hold;
      end else if (!decided && at_pos) begin
        if (coll) begin
          if (take) begin
            tail = nw;
          end
        end else if (!full) begin
          tail = nw;
        end
      end
    end
  end

  // Primary point: first hash at or above the key, else index zero.
  assign hit        = !found && in_ring && head.hash >= nw.hash;
  assign prim_f     = found ? prim : (hit ? head.owner : owner0);
  assign prim_idx_f = found ? prim_idx : (hit ? step : '0);

  assign bit_sel = SEEN_W'(1) << head.owner;
  assign new_bit = (seen & bit_sel) == '0;
  assign dist_n  = distinct + 7'(new_bit);
  assign walk    = !done && in_ring &&
                   (((pass == 2'd1) && (step > prim_idx)) ||
                    ((pass == 2'd2) && (step <= prim_idx)));

  assign modulus = (inst_cnt == 7'd0) ? 7'd1 : inst_cnt;
  assign rem_sh  = {rem, rep_bits[REPLICA_W-1]};

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      inst_cnt <= 7'd1;
    end else if (cfg_we) begin
      inst_cnt <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      pass         <= '0;
      count        <= '0;
      out_ch.valid <= 1'b0;
      seen         <= '0;
    end else begin
      // Drop the result once out_ch takes it, unless a new one loads.
      if (out_ch.valid && out_ch.ready && state != S_RESP) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r      <= in_ch.op;
            nw.hash   <= in_ch.point_hash;
            nw.owner  <= in_ch.instance_id;
            nw.weight <= in_ch.weight;
            nw.ip     <= in_ch.ip_address;
            nw.port   <= in_ch.port_number;
            rep_bits  <= in_ch.replica;
            step      <= '0;
            pass      <= '0;
            decided   <= 1'b0;
            ins       <= 1'b0;
            found     <= 1'b0;
            done      <= 1'b0;
            rem       <= '0;
            div_cnt   <= '0;
            res_inst  <= '0;
            case (in_ch.op)
              OP_CLEAR: begin
                count      <= '0;
                res_status <= ST_CLEARED;
                state      <= S_RESP;
              end
              OP_INSERT: begin
                // A full ring with no slot found by the scan stays full.
                res_status <= ST_FULL;
                state      <= S_ROT;
              end
              OP_LOOKUP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  state <= S_DIV;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV: begin
          // Restoring remainder, most significant replica bit first.
          rem      <= (rem_sh >= {1'b0, modulus}) ? 7'(rem_sh - {1'b0, modulus})
                                                  : rem_sh[6:0];
          rep_bits <= {rep_bits[REPLICA_W-2:0], 1'b0};
          div_cnt  <= div_cnt + 5'd1;
          if (div_cnt == 5'(REPLICA_W - 1)) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          step <= (step == LAST_STEP) ? '0 : step + STEP_W'(1);
          if (op_r == OP_INSERT) begin
            if (ins) begin
              hold <= head;
            end else if (!decided && at_pos) begin
              decided <= 1'b1;
              if (coll) begin
                res_status <= take ? ST_REPLACED : ST_KEPT;
              end else if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_INSERTED;
                hold       <= head;
                ins        <= 1'b1;
                count      <= count + CNT_W'(1);
              end
            end
            if (step == LAST_STEP) begin
              state <= S_RESP;
            end
          end else begin
            res_status <= ST_FOUND;
            if (pass == 2'd0) begin
              if (step == '0) begin
                owner0 <= head.owner;
              end
              if (step == LAST_STEP) begin
                prim     <= prim_f;
                prim_idx <= prim_idx_f;
                if (rem == '0) begin
                  res_inst <= prim_f;
                  state    <= S_RESP;
                end else begin
                  seen     <= SEEN_W'(1) << prim_f;
                  distinct <= 7'd1;
                  pass     <= 2'd1;
                end
              end else if (hit) begin
                found    <= 1'b1;
                prim     <= head.owner;
                prim_idx <= step;
              end
            end else begin
              if (walk) begin
                if (new_bit) begin
                  seen     <= seen | bit_sel;
                  distinct <= dist_n;
                end
                if (dist_n > rem) begin
                  done <= 1'b1;
                  ans  <= head.owner;
                end
              end
              if (step == LAST_STEP) begin
                if (pass == 2'd1) begin
                  pass <= 2'd2;
                end else begin
                  res_inst <= (walk && dist_n > rem) ? head.owner : (done ? ans : prim);
                  state    <= S_RESP;
                end
              end
            end
          end
        end
        S_RESP: begin
          // Hold until the output register is free.
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid           <= 1'b1;
            out_ch.status          <= res_status;
            out_ch.chosen_instance <= res_inst;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHR_ASSERT(a_count_bound, count <= CNT_W'(RING_DEPTH), "entry count beyond ring depth")
  `CHR_IMPLIES(a_step_idle, state != S_ROT, step == '0, "rotation step off zero outside scan")
  `CHR_IMPLIES(a_pass_insert, state == S_ROT && op_r == OP_INSERT, pass == 2'd0,
               "insert scan left its single pass")
  `CHR_IMPLIES(a_walk_count, state == S_ROT && pass != 2'd0, distinct <= 7'd64,
               "walk gathered more instances than exist")
endmodule

[verif/consistent_hash_ring_tb.sv]
`timescale 1ns / 1ps

module consistent_hash_ring_tb;
  import chr_pkg::*;

  localparam int RING_DEPTH = 1024;
  // Unused op code: the block drops it without a response.
  localparam logic [1:0] OP_NONE = 2'd3;
  // Longest job: replica remainder plus a lookup with a full walk of the ring.
  localparam int DRAIN_CYCLES = 3 * RING_DEPTH + 64;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    logic [5:0]  id;
    logic [15:0] weight;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] replica;
  } ring_req_t;

  typedef struct {
    logic [2:0] status;
    logic [5:0] chosen;
  } ring_resp_t;

  typedef struct {
    int         cfg;      // instance count to load first, -1 for none
    ring_req_t  req;
    bit         typed;    // response typed in below instead of predicted
    ring_resp_t resp;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [6:0] cfg_data;

  chr_in_if  in_ch();
  chr_out_if out_ch();

  consistent_hash_ring #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the ring, kept sorted by hash.
  logic [31:0] shadow_hash[RING_DEPTH];
  logic [5:0]  shadow_owner[RING_DEPTH];
  logic [15:0] shadow_weight[RING_DEPTH];
  logic [31:0] shadow_ip[RING_DEPTH];
  logic [15:0] shadow_port[RING_DEPTH];
  int          shadow_count;
  logic [6:0]  shadow_instances;

  ring_resp_t  pending_resp[$];
  int          fail_count;
  int          sent_count;
  int          resp_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold the whole run to a hard ceiling.
  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int first_at_least(logic [31:0] key);
    int i;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_hash[i] >= key) return i;
    end
    return shadow_count;
  endfunction

  function automatic logic [2:0] shadow_insert(ring_req_t r);
    int  pos;
    int  j;
    bit  take;
    pos = first_at_least(r.key);
    if (pos < shadow_count && shadow_hash[pos] == r.key) begin
      // Collision: weight, then lower IP, then lower-or-equal port wins.
      if (r.weight != shadow_weight[pos]) take = r.weight > shadow_weight[pos];
      else if (r.ip != shadow_ip[pos]) take = r.ip < shadow_ip[pos];
      else take = r.port <= shadow_port[pos];
      if (!take) return ST_KEPT;
      shadow_owner[pos]  = r.id;
      shadow_weight[pos] = r.weight;
      shadow_ip[pos]     = r.ip;
      shadow_port[pos]   = r.port;
      return ST_REPLACED;
    end
    if (shadow_count >= RING_DEPTH) return ST_FULL;
    for (j = shadow_count; j > pos; j--) begin
      shadow_hash[j]   = shadow_hash[j-1];
      shadow_owner[j]  = shadow_owner[j-1];
      shadow_weight[j] = shadow_weight[j-1];
      shadow_ip[j]     = shadow_ip[j-1];
      shadow_port[j]   = shadow_port[j-1];
    end
    shadow_hash[pos]   = r.key;
    shadow_owner[pos]  = r.id;
    shadow_weight[pos] = r.weight;
    shadow_ip[pos]     = r.ip;
    shadow_port[pos]   = r.port;
    shadow_count++;
    return ST_INSERTED;
  endfunction

  function automatic logic [5:0] shadow_lookup(ring_req_t r);
    int          primary;
    int          modulus;
    int          wanted;
    int          p;
    int          i;
    int          distinct;
    logic [63:0] seen;
    primary = first_at_least(r.key);
    if (primary >= shadow_count) primary = 0;
    modulus = (shadow_instances == 0) ? 1 : shadow_instances;
    wanted  = r.replica % modulus;
    if (wanted == 0) return shadow_owner[primary];
    // Walk clockwise gathering distinct owners until one passes the replica.
    p        = primary;
    seen     = 64'd1 << shadow_owner[p];
    distinct = 1;
    for (i = 0; i < shadow_count; i++) begin
      p = (p + 1 >= shadow_count) ? 0 : p + 1;
      if (!seen[shadow_owner[p]]) begin
        seen[shadow_owner[p]] = 1'b1;
        distinct++;
      end
      if (distinct > wanted) return shadow_owner[p];
    end
    return shadow_owner[primary];
  endfunction

  // Advance the shadow ring by one accepted transaction; returns 0 if no response.
  function automatic bit predict_response(ring_req_t r, output ring_resp_t resp);
    resp.chosen = 6'd0;
    case (r.op)
      OP_CLEAR: begin
        shadow_count = 0;
        resp.status  = ST_CLEARED;
      end
      OP_INSERT: begin
        resp.status = shadow_insert(r);
      end
      OP_LOOKUP: begin
        if (shadow_count == 0) begin
          resp.status = ST_EMPTY;
        end else begin
          resp.status = ST_FOUND;
          resp.chosen = shadow_lookup(r);
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic dir_row_t row(int cfg, logic [1:0] op, logic [31:0] key, logic [5:0] id,
                                   logic [15:0] w, logic [31:0] ip, logic [15:0] port,
                                   logic [15:0] rep, bit typed, logic [2:0] st,
                                   logic [5:0] ch);
    dir_row_t d;
    d.cfg = cfg;
    d.req = '{op, key, id, w, ip, port, rep};
    d.typed = typed;
    d.resp = '{st, ch};
    return d;
  endfunction

  // Offer one transaction, with random gaps outside the quiet stretch.
  task automatic send(ring_req_t r, bit typed, ring_resp_t typed_resp);
    ring_resp_t resp;
    bit         has_resp;
    while (!(sent_count >= 300 && sent_count < 500) && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= r.op;
    in_ch.point_hash  <= r.key;
    in_ch.instance_id <= r.id;
    in_ch.weight      <= r.weight;
    in_ch.ip_address  <= r.ip;
    in_ch.port_number <= r.port;
    in_ch.replica     <= r.replica;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    has_resp = predict_response(r, resp);
    if (has_resp) pending_resp.push_back(typed ? typed_resp : resp);
  endtask

  // Drain the block, then load a new instance count.
  task automatic load_instances(logic [6:0] v);
    in_ch.valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_instances = v;
  endtask

  function automatic logic [31:0] pick_hash();
    case ($urandom_range(3))
      0: return $urandom_range(7) * 32'h2000_0000;
      1: return 32'hFFFF_FFF8 + $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic ring_req_t random_req();
    ring_req_t r;
    int        sel;
    sel = $urandom_range(99);
    if (sel < 2) r.op = OP_CLEAR;
    else if (sel < 5) r.op = OP_NONE;
    else if (sel < 62) r.op = OP_INSERT;
    else r.op = OP_LOOKUP;
    r.key     = pick_hash();
    r.id      = $urandom_range(63);
    r.weight  = $urandom_range(1) ? 16'($urandom_range(2)) : 16'($urandom);
    r.ip      = $urandom_range(1) ? 32'($urandom_range(2)) : 32'($urandom);
    r.port    = $urandom_range(1) ? 16'($urandom_range(2)) : 16'($urandom);
    r.replica = $urandom_range(9) < 7 ? 16'($urandom_range(2 * shadow_instances + 2))
                                       : 16'($urandom);
    return r;
  endfunction

  // Response side: random back-pressure, one long hold-off to back up the input.
  initial begin
    bit held;
    ring_resp_t exp_resp;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    resp_count = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_resp.size() == 0) begin
          $error("unexpected response status %0d chosen_instance %0d",
                 out_ch.status, out_ch.chosen_instance);
          fail_count++;
        end else begin
          exp_resp = pending_resp.pop_front();
          if (out_ch.status !== exp_resp.status) begin
            $error("status expected %0d actual %0d", exp_resp.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.chosen_instance !== exp_resp.chosen) begin
            $error("chosen_instance expected %0d actual %0d", exp_resp.chosen,
                   out_ch.chosen_instance);
            fail_count++;
          end
        end
        resp_count++;
      end
      if (resp_count == 100 && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (6000) @(posedge clk);
      end else begin
        out_ch.ready <= (resp_count >= 300 && resp_count < 500) || $urandom_range(99) >= 29;
      end
    end
  end

  initial begin
    dir_row_t   dir_rows[$];
    ring_req_t  r;
    ring_resp_t none;
    int         cfg_list[$];
    int         i;
    int         k;

    fail_count   = 0;
    sent_count   = 0;
    shadow_count = 0;
    shadow_instances = 7'd1;
    none = '{ST_INSERTED, 6'd0};
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= 7'd0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_CLEAR;
    in_ch.point_hash <= '0;
    in_ch.instance_id <= '0;
    in_ch.weight     <= '0;
    in_ch.ip_address <= '0;
    in_ch.port_number <= '0;
    in_ch.replica    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty ring, extremes, every collision outcome, wrap and replica walks.
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h0, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
    dir_rows.push_back(row(-1, OP_CLEAR, 32'h0, 0, 0, 0, 0, 0, 1, ST_CLEARED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h0, 0, 0, 0, 0, 0, 1, ST_INSERTED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, '1, 63, '1, '1, '1, '1, 1, ST_INSERTED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 21, 100, 10, 80, 0, 1,
                           ST_INSERTED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 42, 200, 10, 80, 0, 1,
                           ST_REPLACED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 5, 100, 0, 0, 0, 1, ST_KEPT, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 7, 200, 5, 90, 0, 1,
                           ST_REPLACED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 9, 200, 5, 90, 0, 1,
                           ST_REPLACED, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 11, 200, 5, 91, 0, 1, ST_KEPT, 0));
    dir_rows.push_back(row(-1, OP_INSERT, 32'h8000_0000, 12, 200, 6, 0, 0, 1, ST_KEPT, 0));
    dir_rows.push_back(row(-1, OP_NONE, '1, 1, 1, 1, 1, 1, 0, 0, 0));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h0, 0, 0, 0, 0, 0, 1, ST_FOUND, 0));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h8000_0000, 0, 0, 0, 0, 0, 1, ST_FOUND, 9));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h8000_0001, 0, 0, 0, 0, 0, 1, ST_FOUND, 63));
    dir_rows.push_back(row(-1, OP_LOOKUP, '1, 0, 0, 0, 0, '1, 1, ST_FOUND, 63));
    dir_rows.push_back(row(3, OP_LOOKUP, 32'h0, 0, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h0, 0, 0, 0, 0, 2, 0, 0, 0));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h0, 0, 0, 0, 0, 3, 0, 0, 0));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, '1, 0, 0, 0));
    dir_rows.push_back(row(64, OP_LOOKUP, 32'h4000_0000, 0, 0, 0, 0, 5, 0, 0, 0));
    dir_rows.push_back(row(0, OP_LOOKUP, 32'h4000_0000, 0, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(-1, OP_CLEAR, 32'h0, 0, 0, 0, 0, 0, 1, ST_CLEARED, 0));
    dir_rows.push_back(row(-1, OP_LOOKUP, 32'h1234_5678, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0));

    foreach (dir_rows[n]) begin
      if (dir_rows[n].cfg >= 0) load_instances(7'(dir_rows[n].cfg));
      send(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].resp);
    end

    // Random phases over several instance counts, each from an empty ring.
    cfg_list = '{1, 3, 127, 64, 2, 5, 0};
    foreach (cfg_list[n]) begin
      load_instances(7'(cfg_list[n]));
      r = random_req();
      r.op = OP_CLEAR;
      send(r, 0, none);
      for (i = 0; i < 55; i++) send(random_req(), 0, none);
    end

    // Fill the ring to capacity with lookups mixed in, then hit it while full.
    load_instances(7'd7);
    r = random_req();
    r.op = OP_CLEAR;
    send(r, 0, none);
    k = 0;
    while (shadow_count < RING_DEPTH) begin
      r = random_req();
      r.op = (k % 25 == 24) ? OP_LOOKUP : OP_INSERT;
      r.key = $urandom;
      send(r, 0, none);
      k++;
    end
    for (i = 0; i < 60; i++) begin
      r = random_req();
      if (r.op == OP_CLEAR) r.op = OP_LOOKUP;
      if (r.op == OP_INSERT && $urandom_range(1)) r.key = shadow_hash[$urandom_range(RING_DEPTH - 1)];
      send(r, 0, none);
    end

    load_instances(7'd4);
    for (i = 0; i < 80; i++) send(random_req(), 0, none);
    in_ch.valid <= 1'b0;

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
